/* design/frs_pkg.sv */
// ----------------------------------------------------------------------------
// frs_pkg : shared definitions for the file receiver sequencer
// Phase, packet kind, reply and abort codes, register indexes and the
// layout of one result item.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

    // Register file
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 1'b1;
    localparam logic [5:0]  RETRY_LIMIT_RST = 6'd10;

    // Retry counters saturate at this value
    localparam logic [6:0]  TRY_MAX         = 7'd127;

    // Transfer phase
    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_FILE  = 3'd1,
        PH_DATA  = 3'd2,
        PH_DONE  = 3'd3,
        PH_ABORT = 3'd4
    } phase_t;

    // Received packet kinds; codes above KIND_OTHER are illegal as well
    typedef enum logic [3:0] {
        KIND_TIMEOUT = 4'd0,
        KIND_INIT    = 4'd1,
        KIND_FHDR    = 4'd2,
        KIND_DATA    = 4'd3,
        KIND_EOF     = 4'd4,
        KIND_BREAK   = 4'd5,
        KIND_ATTR    = 4'd6,
        KIND_ERROR   = 4'd7,
        KIND_OTHER   = 4'd8
    } kind_t;

    // Reply to send
    typedef enum logic [1:0] {
        RPL_NONE = 2'd0,
        RPL_ACK  = 2'd1,
        RPL_NAK  = 2'd2
    } reply_t;

    // Abort cause
    typedef enum logic [2:0] {
        AC_NONE    = 3'd0,
        AC_TRIES   = 3'd1,
        AC_NUMBER  = 3'd2,
        AC_ILLEGAL = 3'd3,
        AC_ERRPKT  = 3'd4,
        AC_FILE    = 3'd5
    } cause_t;

    // File type tag of an attribute packet
    typedef enum logic [1:0] {
        FT_UNKNOWN = 2'd0,
        FT_TEXT    = 2'd1,
        FT_BINARY  = 2'd2,
        FT_IMAGE   = 2'd3
    } ftype_t;

    // One result item as held in the output stage
    typedef struct packed {
        reply_t     send_kind;
        logic [5:0] send_num;
        phase_t     phase_now;
        logic       write_data;
        logic       file_done;
        logic       is_binary;
        logic       is_image;
        cause_t     abort_cause;
    } res_t;

endpackage

`default_nettype wire

/* design/frs_pkt_if.sv */
// ----------------------------------------------------------------------------
// frs_pkt_if : received packet event channel
// Valid/ready channel carrying one packet event per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface frs_pkt_if;
    logic       valid;
    logic       ready;
    logic [3:0] pkt_kind;
    logic [5:0] pkt_num;
    logic       file_ok;
    logic       store_ok;
    logic       attr_is_type;
    logic [1:0] attr_code;

    modport source (
        output valid, pkt_kind, pkt_num, file_ok, store_ok, attr_is_type, attr_code,
        input  ready
    );

    modport sink (
        input  valid, pkt_kind, pkt_num, file_ok, store_ok, attr_is_type, attr_code,
        output ready
    );
endinterface

`default_nettype wire

/* design/frs_res_if.sv */
// ----------------------------------------------------------------------------
// frs_res_if : sequencer result channel
// Valid/ready channel carrying the reply, strobes and status of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface frs_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] send_kind;
    logic [5:0] send_num;
    logic [2:0] phase_now;
    logic       write_data;
    logic       file_done;
    logic       is_binary;
    logic       is_image;
    logic [2:0] abort_cause;

    modport source (
        output valid, send_kind, send_num, phase_now, write_data, file_done,
               is_binary, is_image, abort_cause,
        input  ready
    );

    modport sink (
        input  valid, send_kind, send_num, phase_now, write_data, file_done,
               is_binary, is_image, abort_cause,
        output ready
    );
endinterface

`default_nettype wire

/* design/file_receiver_sequencer.sv */
// ----------------------------------------------------------------------------
// file_receiver_sequencer : stop-and-wait file transfer receive sequencer
// Tracks phase, expected sequence number and retry counts, and answers each
// received packet event with a reply, write/close strobes and status.
// ----------------------------------------------------------------------------
// Each packet event is decided in the cycle it is accepted: the phase,
// sequence and retry registers update at that edge and the result item is
// loaded into a two-entry output stage (output register plus skid register).
// One item is taken every cycle; pkt.ready drops only when both entries are
// full, and the skid register takes a result only while the output item is
// held. Once the phase reaches complete or aborted every later item gets an
// empty reply until reset. The user must write retry_limit and filter_mode via
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none

module file_receiver_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [frs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    frs_pkt_if.sink                            pkt,
    frs_res_if.source                          res
);

    // Configuration and sequencer state
    logic [5:0]      retry_limit_reg;
    logic            filter_mode_reg;
    frs_pkg::phase_t phase_reg, phase_next;
    logic [5:0]      seq_reg, seq_next;
    logic [6:0]      try_reg, try_next;
    logic [6:0]      prev_reg, prev_next;
    logic            bin_reg, bin_next;
    logic            img_reg, img_next;

    // Decision of the current item
    frs_pkg::reply_t dec_kind;
    logic [5:0]      dec_num;
    logic            dec_wr;
    logic            dec_fd;
    frs_pkg::cause_t dec_cause;
    frs_pkg::res_t   res_new;

    // Output stage
    frs_pkg::res_t   out_reg, skid_reg;
    logic            out_valid_reg, skid_valid_reg;

    logic            accept;
    logic            out_fire;
    logic [6:0]      limit_ext;
    logic [6:0]      try_bump;
    logic [6:0]      prev_bump;
    logic            try_over;
    logic            prev_over;
    logic [5:0]      seq_prev;
    logic [5:0]      seq_inc;

    function automatic logic [6:0] bump(input logic [6:0] c);
        bump = (c == frs_pkg::TRY_MAX) ? c : c + 7'd1;
    endfunction

    assign accept    = pkt.valid && pkt.ready;
    assign out_fire  = out_valid_reg && res.ready;
    assign pkt.ready = !skid_valid_reg;

    assign limit_ext = {1'b0, retry_limit_reg};
    assign try_bump  = bump(try_reg);
    assign prev_bump = bump(prev_reg);
    assign try_over  = try_reg > limit_ext;
    assign prev_over = prev_reg > limit_ext;
    assign seq_prev  = seq_reg - 6'd1;
    assign seq_inc   = seq_reg + 6'd1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= frs_pkg::RETRY_LIMIT_RST;
            filter_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                frs_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata;
                frs_pkg::CFG_FILTER_MODE: filter_mode_reg <= cfg_wdata[0];
                default:                  ;
            endcase
        end
    end

    // Next state and decision for the offered item
    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        try_next   = try_reg;
        prev_next  = prev_reg;
        bin_next   = bin_reg;
        img_next   = img_reg;
        dec_kind   = frs_pkg::RPL_NONE;
        dec_num    = '0;
        dec_wr     = 1'b0;
        dec_fd     = 1'b0;
        dec_cause  = frs_pkg::AC_NONE;

        if (phase_reg == frs_pkg::PH_INIT || phase_reg == frs_pkg::PH_FILE ||
            phase_reg == frs_pkg::PH_DATA)
        begin
            if (try_over)
            begin
                dec_cause = frs_pkg::AC_TRIES;
            end
            else
            begin
                try_next = try_bump;
                if (pkt.pkt_kind == frs_pkg::KIND_TIMEOUT)
                begin
                    dec_kind = frs_pkg::RPL_NAK;
                    dec_num  = seq_reg;
                end
                else if (pkt.pkt_kind == frs_pkg::KIND_ERROR)
                begin
                    dec_cause = frs_pkg::AC_ERRPKT;
                end
                else if (phase_reg == frs_pkg::PH_INIT)
                begin
                    if (pkt.pkt_kind == frs_pkg::KIND_INIT)
                    begin
                        dec_kind   = frs_pkg::RPL_ACK;
                        dec_num    = seq_reg;
                        prev_next  = try_bump;
                        try_next   = '0;
                        seq_next   = seq_inc;
                        phase_next = frs_pkg::PH_FILE;
                    end
                    else
                    begin
                        dec_cause = frs_pkg::AC_ILLEGAL;
                    end
                end
                else if (phase_reg == frs_pkg::PH_FILE)
                begin
                    // File header phase
                    unique case (pkt.pkt_kind)
                        frs_pkg::KIND_INIT, frs_pkg::KIND_EOF:
                        begin
                            if (prev_over)
                                dec_cause = frs_pkg::AC_TRIES;
                            else
                            begin
                                prev_next = prev_bump;
                                if (pkt.pkt_num == seq_prev)
                                begin
                                    dec_kind = frs_pkg::RPL_ACK;
                                    dec_num  = pkt.pkt_num;
                                    try_next = '0;
                                end
                                else
                                    dec_cause = frs_pkg::AC_NUMBER;
                            end
                        end
                        frs_pkg::KIND_FHDR:
                        begin
                            if (pkt.pkt_num != seq_reg)
                            begin
                                if (!filter_mode_reg)
                                    dec_cause = frs_pkg::AC_NUMBER;
                            end
                            else if (!pkt.file_ok)
                                dec_cause = frs_pkg::AC_FILE;
                            else
                            begin
                                dec_kind   = frs_pkg::RPL_ACK;
                                dec_num    = seq_reg;
                                prev_next  = try_bump;
                                try_next   = '0;
                                seq_next   = seq_inc;
                                phase_next = frs_pkg::PH_DATA;
                            end
                        end
                        frs_pkg::KIND_BREAK:
                        begin
                            if (pkt.pkt_num != seq_reg)
                                dec_cause = frs_pkg::AC_NUMBER;
                            else
                            begin
                                dec_kind   = frs_pkg::RPL_ACK;
                                dec_num    = seq_reg;
                                phase_next = frs_pkg::PH_DONE;
                            end
                        end
                        default:
                            dec_cause = frs_pkg::AC_ILLEGAL;
                    endcase
                end
                else
                begin
                    // Data phase
                    unique case (pkt.pkt_kind)
                        frs_pkg::KIND_DATA:
                        begin
                            if (pkt.pkt_num != seq_reg)
                            begin
                                if (prev_over)
                                    dec_cause = frs_pkg::AC_NUMBER;
                                else
                                begin
                                    prev_next = prev_bump;
                                    if (pkt.pkt_num == seq_prev)
                                    begin
                                        dec_kind = frs_pkg::RPL_ACK;
                                        dec_num  = pkt.pkt_num;
                                        try_next = '0;
                                    end
                                    else if (!filter_mode_reg)
                                        dec_cause = frs_pkg::AC_NUMBER;
                                end
                            end
                            else
                            begin
                                dec_wr    = 1'b1;
                                dec_kind  = frs_pkg::RPL_ACK;
                                dec_num   = seq_reg;
                                prev_next = try_bump;
                                try_next  = '0;
                                seq_next  = seq_inc;
                                if (!pkt.store_ok)
                                    dec_cause = frs_pkg::AC_FILE;
                            end
                        end
                        frs_pkg::KIND_FHDR:
                        begin
                            if (prev_over)
                                dec_cause = frs_pkg::AC_TRIES;
                            else
                            begin
                                prev_next = prev_bump;
                                if (pkt.pkt_num == seq_prev)
                                begin
                                    dec_kind = frs_pkg::RPL_ACK;
                                    dec_num  = pkt.pkt_num;
                                    try_next = '0;
                                end
                                else
                                    dec_cause = frs_pkg::AC_NUMBER;
                            end
                        end
                        frs_pkg::KIND_ATTR:
                        begin
                            if (pkt.pkt_num == seq_prev)
                            begin
                                dec_kind = frs_pkg::RPL_ACK;
                                dec_num  = pkt.pkt_num;
                            end
                            else if (pkt.pkt_num == seq_reg)
                            begin
                                dec_kind = frs_pkg::RPL_ACK;
                                dec_num  = seq_reg;
                                try_next = '0;
                                seq_next = seq_inc;
                                if (pkt.attr_is_type)
                                begin
                                    unique case (pkt.attr_code)
                                        frs_pkg::FT_TEXT:
                                        begin
                                            bin_next = 1'b0;
                                            img_next = 1'b0;
                                        end
                                        frs_pkg::FT_BINARY:
                                        begin
                                            bin_next = 1'b1;
                                            img_next = 1'b0;
                                        end
                                        frs_pkg::FT_IMAGE:
                                        begin
                                            bin_next = 1'b1;
                                            img_next = 1'b1;
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            else
                                dec_cause = frs_pkg::AC_NUMBER;
                        end
                        frs_pkg::KIND_EOF:
                        begin
                            if (pkt.pkt_num != seq_reg)
                                dec_cause = frs_pkg::AC_NUMBER;
                            else
                            begin
                                dec_kind   = frs_pkg::RPL_ACK;
                                dec_num    = seq_reg;
                                dec_fd     = 1'b1;
                                seq_next   = seq_inc;
                                phase_next = frs_pkg::PH_FILE;
                            end
                        end
                        default:
                            dec_cause = frs_pkg::AC_ILLEGAL;
                    endcase
                end
            end

            if (dec_cause != frs_pkg::AC_NONE)
                phase_next = frs_pkg::PH_ABORT;
        end
    end

    // Result item; an abort suppresses the reply unless data was written
    always_comb
    begin
        res_new.send_kind   = dec_kind;
        res_new.send_num    = dec_num;
        res_new.phase_now   = phase_next;
        res_new.write_data  = dec_wr;
        res_new.file_done   = dec_fd;
        res_new.is_binary   = bin_next;
        res_new.is_image    = img_next;
        res_new.abort_cause = dec_cause;
        if (dec_cause != frs_pkg::AC_NONE &&
            !(dec_cause == frs_pkg::AC_FILE && dec_wr))
        begin
            res_new.send_kind = frs_pkg::RPL_NONE;
            res_new.send_num  = '0;
        end
    end

    // Sequencer state update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= frs_pkg::PH_INIT;
            seq_reg   <= '0;
            try_reg   <= '0;
            prev_reg  <= '0;
            bin_reg   <= 1'b0;
            img_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            try_reg   <= try_next;
            prev_reg  <= prev_next;
            bin_reg   <= bin_next;
            img_reg   <= img_next;
        end
    end

    // Output stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= res_new;
            else
                skid_reg <= res_new;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.send_kind   = out_reg.send_kind;
    assign res.send_num    = out_reg.send_num;
    assign res.phase_now   = out_reg.phase_now;
    assign res.write_data  = out_reg.write_data;
    assign res.file_done   = out_reg.file_done;
    assign res.is_binary   = out_reg.is_binary;
    assign res.is_image    = out_reg.is_image;
    assign res.abort_cause = out_reg.abort_cause;

`ifndef ASSERT_OFF
    // Skid entry only ever fills behind a held output item
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // Finished phases are terminal
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == frs_pkg::PH_DONE || phase_reg == frs_pkg::PH_ABORT)
        |=> phase_reg == $past(phase_reg))
        else $error("left a finished phase without reset");

    // An accepted item with an abort cause moves to the aborted phase
    a_abort_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec_cause != frs_pkg::AC_NONE) |=> phase_reg == frs_pkg::PH_ABORT)
        else $error("abort cause without aborted phase");

    // A data write strobe always goes out with an ACK
    a_write_acked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.write_data) |-> out_reg.send_kind == frs_pkg::RPL_ACK)
        else $error("data write strobe without ACK");

    // An abort never carries a reply other than a write acknowledgement
    a_abort_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.abort_cause != frs_pkg::AC_NONE && !out_reg.write_data)
        |-> out_reg.send_kind == frs_pkg::RPL_NONE)
        else $error("reply sent on aborting item");
`endif

endmodule

`default_nettype wire
